// ----- rtl/psie_pkg.sv -----
// ----------------------------------------------------------------------------
// psie_pkg
// Types, constants and helpers shared by the skip interval engine.
// ----------------------------------------------------------------------------
package psie_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 16;
  localparam int unsigned RANGE_CNT_W       = 5;
  localparam logic [31:0] BACK_STEP_MS      = 32'd10;
  localparam logic [31:0] MIN_LEN_MS        = 32'd1;

  typedef enum logic [2:0] {
    CMD_POSITION = 3'd0,
    CMD_REL_SEEK = 3'd1,
    CMD_MARK     = 3'd2,
    CMD_ADD      = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_STOP     = 3'd5,
    CMD_FINISHED = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_RD,
    ST_POS_CHK,
    ST_SEEK_RD,
    ST_SEEK_CHK,
    ST_SEEK_END,
    ST_INS_RD,
    ST_INS_PROC,
    ST_INS_TAIL,
    ST_INS_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               paused;
    logic [31:0]        position_ms;
    logic signed [31:0] delta_ms;
    logic [31:0]        range_start_ms;
    logic [31:0]        range_end_ms;
  } in_beat_t;

  typedef struct packed {
    logic                   seek_valid;
    logic [31:0]            seek_target_ms;
    logic                   finish_request;
    logic                   mark_pending;
    logic [31:0]            mark_start_ms;
    logic [RANGE_CNT_W-1:0] range_count;
    logic                   table_overflow;
  } out_beat_t;

  function automatic logic [31:0] clamp_end(input logic [31:0] e, input logic [31:0] dur);
    clamp_end = (dur != 32'd0 && e > dur) ? dur : e;
  endfunction

  // true when the interval [s, e) is empty or at most one millisecond long
  function automatic logic is_short(input logic [31:0] s, input logic [31:0] e);
    is_short = ({1'b0, e} <= ({1'b0, s} + {1'b0, MIN_LEN_MS}));
  endfunction

endpackage

// ----- rtl/psie_ram.sv -----
// ----------------------------------------------------------------------------
// psie_ram
// Interval store: two banks of start/end pairs, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module psie_ram #(
  parameter int unsigned AW = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/psie_seq.sv -----
// ----------------------------------------------------------------------------
// psie_seq
// Command sequencer: walks the interval store one entry per step for
// position checks, seek resolution and merged inserts.
// ----------------------------------------------------------------------------
module psie_seq #(
  parameter int unsigned MAX_INTERVALS = psie_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
  parameter int unsigned AW = IW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psie_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output psie_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [63:0]         wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [63:0]         rd_data
);

  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned MW = $clog2(MAX_INTERVALS + 2);
  localparam logic [MW-1:0] MAX_M = MW'(MAX_INTERVALS);

  psie_pkg::state_t state_r, state_nxt;

  logic [31:0]   dur_r, dur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          bank_r, bank_nxt;
  logic [31:0]   cur_pos_r, cur_pos_nxt;
  logic          mark_flag_r, mark_flag_nxt;
  logic [31:0]   mark_start_r, mark_start_nxt;
  logic          jump_r, jump_nxt;
  logic          fin_pend_r, fin_pend_nxt;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [MW-1:0] pass_r, pass_nxt;
  logic [MW-1:0] m_r, m_nxt;
  logic [31:0]   t_r, t_nxt;
  logic          fwd_r, fwd_nxt;
  logic [31:0]   new_s_r, new_s_nxt, new_e_r, new_e_nxt;
  logic          new_v_r, new_v_nxt;
  logic [31:0]   last_s_r, last_s_nxt, last_e_r, last_e_nxt;
  logic          last_v_r, last_v_nxt;

  logic          seek_r, seek_nxt;
  logic [31:0]   target_r, target_nxt;
  logic          fin_r, fin_nxt;
  logic          ovf_r, ovf_nxt;

  logic [31:0] ent_s, ent_e, ent_ec;
  logic        ent_v;
  logic        last_idx;

  assign ent_s    = rd_data[63:32];
  assign ent_e    = rd_data[31:0];
  assign ent_ec   = psie_pkg::clamp_end(ent_e, dur_r);
  assign ent_v    = !psie_pkg::is_short(ent_s, ent_ec);
  assign last_idx = (CW'(idx_r + 1'b1) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psie_pkg::ST_IDLE;
      dur_r        <= '0;
      cnt_r        <= '0;
      bank_r       <= 1'b0;
      cur_pos_r    <= '0;
      mark_flag_r  <= 1'b0;
      mark_start_r <= '0;
      jump_r       <= 1'b0;
      fin_pend_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dur_r        <= dur_nxt;
      cnt_r        <= cnt_nxt;
      bank_r       <= bank_nxt;
      cur_pos_r    <= cur_pos_nxt;
      mark_flag_r  <= mark_flag_nxt;
      mark_start_r <= mark_start_nxt;
      jump_r       <= jump_nxt;
      fin_pend_r   <= fin_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pass_r   <= pass_nxt;
    m_r      <= m_nxt;
    t_r      <= t_nxt;
    fwd_r    <= fwd_nxt;
    new_s_r  <= new_s_nxt;
    new_e_r  <= new_e_nxt;
    new_v_r  <= new_v_nxt;
    last_s_r <= last_s_nxt;
    last_e_r <= last_e_nxt;
    last_v_r <= last_v_nxt;
    seek_r   <= seek_nxt;
    target_r <= target_nxt;
    fin_r    <= fin_nxt;
    ovf_r    <= ovf_nxt;
  end

  always_comb begin
    logic [31:0]        a_s, a_e, n_ec, p_s, p_e;
    logic signed [33:0] sum;
    logic [31:0]        tc;
    logic               new_first;
    logic [MW-1:0]      m_fin;
    state_nxt      = state_r;
    dur_nxt        = cfg_we ? cfg_wdata : dur_r;
    cnt_nxt        = cnt_r;
    bank_nxt       = bank_r;
    cur_pos_nxt    = cur_pos_r;
    mark_flag_nxt  = mark_flag_r;
    mark_start_nxt = mark_start_r;
    jump_nxt       = jump_r;
    fin_pend_nxt   = fin_pend_r;
    idx_nxt        = idx_r;
    pass_nxt       = pass_r;
    m_nxt          = m_r;
    t_nxt          = t_r;
    fwd_nxt        = fwd_r;
    new_s_nxt      = new_s_r;
    new_e_nxt      = new_e_r;
    new_v_nxt      = new_v_r;
    last_s_nxt     = last_s_r;
    last_e_nxt     = last_e_r;
    last_v_nxt     = last_v_r;
    seek_nxt       = seek_r;
    target_nxt     = target_r;
    fin_nxt        = fin_r;
    ovf_nxt        = ovf_r;
    wr_en          = 1'b0;
    wr_addr        = {~bank_r, m_r[IW-1:0]};
    wr_data        = {last_s_r, last_e_r};
    rd_en          = 1'b0;
    rd_addr        = {bank_r, idx_r[IW-1:0]};
    a_s            = '0;
    a_e            = '0;
    n_ec           = '0;
    p_s            = '0;
    p_e            = '0;
    sum            = '0;
    tc             = '0;
    new_first      = 1'b0;
    m_fin          = '0;

    unique case (state_r)
      psie_pkg::ST_IDLE: begin
        if (start) begin
          seek_nxt   = 1'b0;
          target_nxt = '0;
          fin_nxt    = 1'b0;
          ovf_nxt    = 1'b0;
          idx_nxt    = '0;
          state_nxt  = psie_pkg::ST_DONE;
          a_s        = in_data.range_start_ms;
          a_e        = in_data.range_end_ms;
          unique case (psie_pkg::cmd_t'(in_data.cmd))
            psie_pkg::CMD_POSITION: begin
              cur_pos_nxt = in_data.position_ms;
              if (jump_r) begin
                jump_nxt = 1'b0;
              end else if (!in_data.paused && cnt_r != '0) begin
                state_nxt = psie_pkg::ST_POS_RD;
              end
            end
            psie_pkg::CMD_REL_SEEK: begin
              if (in_data.delta_ms != '0) begin
                sum = $signed({2'b00, cur_pos_r}) + 34'(in_data.delta_ms);
                if (sum < 0) begin
                  tc = '0;
                end else if (dur_r != '0 && sum > $signed({2'b00, dur_r})) begin
                  tc = dur_r;
                end else if (sum > $signed({2'b00, 32'hFFFF_FFFF})) begin
                  tc = 32'hFFFF_FFFF;
                end else begin
                  tc = sum[31:0];
                end
                t_nxt     = tc;
                fwd_nxt   = !in_data.delta_ms[31];
                pass_nxt  = MW'(1);
                state_nxt = (cnt_r == '0) ? psie_pkg::ST_SEEK_END : psie_pkg::ST_SEEK_RD;
              end
            end
            psie_pkg::CMD_MARK: begin
              if (in_data.paused) begin
                if (!mark_flag_r) begin
                  mark_flag_nxt  = 1'b1;
                  mark_start_nxt = cur_pos_r;
                end else begin
                  mark_flag_nxt  = 1'b0;
                  mark_start_nxt = '0;
                  a_s            = mark_start_r;
                  a_e            = cur_pos_r;
                  state_nxt      = psie_pkg::ST_INS_RD;
                end
              end
            end
            psie_pkg::CMD_ADD: begin
              state_nxt = psie_pkg::ST_INS_RD;
            end
            psie_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            psie_pkg::CMD_STOP: begin
              jump_nxt       = 1'b0;
              fin_pend_nxt   = 1'b0;
              mark_flag_nxt  = 1'b0;
              mark_start_nxt = '0;
            end
            psie_pkg::CMD_FINISHED: begin
              fin_pend_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          if (state_nxt == psie_pkg::ST_INS_RD) begin
            p_s = (a_s < a_e) ? a_s : a_e;
            p_e = (a_s < a_e) ? a_e : a_s;
            if (psie_pkg::is_short(p_s, p_e)) begin
              state_nxt = psie_pkg::ST_DONE;
            end else begin
              n_ec       = psie_pkg::clamp_end(p_e, dur_r);
              new_s_nxt  = p_s;
              new_e_nxt  = n_ec;
              new_v_nxt  = !psie_pkg::is_short(p_s, n_ec);
              last_v_nxt = 1'b0;
              m_nxt      = '0;
              if (cnt_r == '0) begin
                state_nxt = psie_pkg::ST_INS_TAIL;
              end
            end
          end
        end
      end

      psie_pkg::ST_POS_RD: begin
        rd_en     = 1'b1;
        state_nxt = psie_pkg::ST_POS_CHK;
      end

      psie_pkg::ST_POS_CHK: begin
        if (cur_pos_r >= ent_s && cur_pos_r < ent_e) begin
          if (dur_r != '0 && ent_e >= dur_r) begin
            fin_nxt      = !fin_pend_r;
            fin_pend_nxt = 1'b1;
          end else begin
            jump_nxt   = 1'b1;
            seek_nxt   = 1'b1;
            target_nxt = ent_e;
          end
          state_nxt = psie_pkg::ST_DONE;
        end else if (last_idx) begin
          state_nxt = psie_pkg::ST_DONE;
        end else begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = psie_pkg::ST_POS_RD;
        end
      end

      psie_pkg::ST_SEEK_RD: begin
        rd_en     = 1'b1;
        state_nxt = psie_pkg::ST_SEEK_CHK;
      end

      psie_pkg::ST_SEEK_CHK: begin
        if (fwd_r ? (t_r >= ent_s && t_r < ent_e) : (t_r > ent_s && t_r <= ent_e)) begin
          t_nxt = fwd_r ? ent_e
                        : ((ent_s > psie_pkg::BACK_STEP_MS) ? ent_s - psie_pkg::BACK_STEP_MS
                                                            : 32'd0);
          if (pass_r <= MAX_M) begin
            pass_nxt  = MW'(pass_r + 1'b1);
            idx_nxt   = '0;
            state_nxt = psie_pkg::ST_SEEK_RD;
          end else begin
            state_nxt = psie_pkg::ST_SEEK_END;
          end
        end else if (last_idx) begin
          state_nxt = psie_pkg::ST_SEEK_END;
        end else begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = psie_pkg::ST_SEEK_RD;
        end
      end

      psie_pkg::ST_SEEK_END: begin
        if (dur_r != '0 && t_r >= dur_r) begin
          fin_nxt      = !fin_pend_r;
          fin_pend_nxt = 1'b1;
        end else begin
          jump_nxt   = 1'b1;
          seek_nxt   = 1'b1;
          target_nxt = t_r;
        end
        state_nxt = psie_pkg::ST_DONE;
      end

      psie_pkg::ST_INS_RD: begin
        rd_en     = 1'b1;
        state_nxt = psie_pkg::ST_INS_PROC;
      end

      psie_pkg::ST_INS_PROC, psie_pkg::ST_INS_TAIL: begin
        new_first = new_v_r && (new_s_r < ent_s || (new_s_r == ent_s && new_e_r <= ent_e));
        if (state_r == psie_pkg::ST_INS_TAIL || new_first) begin
          p_s       = new_s_r;
          p_e       = new_e_r;
          new_v_nxt = 1'b0;
        end else begin
          p_s = ent_s;
          p_e = ent_ec;
        end
        if ((state_r == psie_pkg::ST_INS_TAIL) ? new_v_r : (new_first || ent_v)) begin
          if (last_v_r && ({1'b0, p_s} <= ({1'b0, last_e_r} + 33'd1))) begin
            last_e_nxt = (p_e > last_e_r) ? p_e : last_e_r;
          end else begin
            if (last_v_r) begin
              wr_en = (m_r < MAX_M);
              m_nxt = MW'(m_r + 1'b1);
            end
            last_s_nxt = p_s;
            last_e_nxt = p_e;
            last_v_nxt = 1'b1;
          end
        end
        if (state_r == psie_pkg::ST_INS_TAIL) begin
          state_nxt = psie_pkg::ST_INS_FLUSH;
        end else if (!new_first) begin
          if (last_idx) begin
            state_nxt = psie_pkg::ST_INS_TAIL;
          end else begin
            idx_nxt   = CW'(idx_r + 1'b1);
            state_nxt = psie_pkg::ST_INS_RD;
          end
        end
      end

      psie_pkg::ST_INS_FLUSH: begin
        wr_en = last_v_r && (m_r < MAX_M);
        m_fin = MW'(m_r + MW'(last_v_r));
        if (m_fin > MAX_M) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt  = m_fin[CW-1:0];
          bank_nxt = ~bank_r;
        end
        state_nxt = psie_pkg::ST_DONE;
      end

      psie_pkg::ST_DONE: begin
        state_nxt = psie_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = psie_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != psie_pkg::ST_IDLE);
  assign out_valid = (state_r == psie_pkg::ST_DONE);

  always_comb begin
    out_data.seek_valid     = seek_r;
    out_data.seek_target_ms = target_r;
    out_data.finish_request = fin_r;
    out_data.mark_pending   = mark_flag_r;
    out_data.mark_start_ms  = mark_start_r;
    out_data.range_count    = psie_pkg::RANGE_CNT_W'(cnt_r);
    out_data.table_overflow = ovf_r;
  end

endmodule

// ----- rtl/playback_skip_interval_engine_top.sv -----
// ----------------------------------------------------------------------------
// playback_skip_interval_engine_top
// Skip interval table with position checks, interval skipping seeks and
// merged inserts.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a command beat on in_data while busy is low; the beat is
//   taken at that edge and busy stays high until the result has been shown.
//   Exactly one result beat follows each command: out_valid is high for one
//   cycle with out_data, and the receiver cannot stall it.
//   cfg_we/cfg_wdata load the media duration; write only while busy is low.
// Command handling walks the interval store one entry per step
// (read, then check per entry), over the N intervals held:
//   clear, stop, finished, mark start, zero delta, ignored commands: no walk.
//   position event: at most one walk, ending at its first hit.
//   add range / mark end: one walk, then a tail and a flush step; the new
//   interval takes a process step of its own when it sorts ahead of a held one; an interval of 1 ms or less: no walk.
//   relative seek: walk passes over the store, where a pass ends at its
//   first hit and there are at most MAX_INTERVALS+1 passes.
//   The next beat is taken the cycle after out_valid.
// Reset (rst_n low, synchronous) empties the table, clears marking, jump
// and finish state and sets the duration to unknown; no clearing pass.
// ----------------------------------------------------------------------------
module playback_skip_interval_engine_top #(
  parameter int unsigned MAX_INTERVALS = psie_pkg::MAX_INTERVALS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psie_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output psie_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  localparam int unsigned IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned AW = IW + 1;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   wr_data, rd_data;

  psie_seq #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .IW(IW),
    .AW(AW)
  ) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  psie_ram #(
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

// ----- rtl/psie_checker.sv -----
// ----------------------------------------------------------------------------
// psie_checker
// Port-level checks of the command and result beats.
// ----------------------------------------------------------------------------
module psie_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input psie_pkg::out_beat_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while not busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_seek_xor_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.seek_valid && out_data.finish_request))
    else $error("seek and finish in one result");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.seek_valid) |-> (out_data.seek_target_ms == 32'd0))
    else $error("seek target set without seek");

endmodule

bind playback_skip_interval_engine_top psie_checker u_psie_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_data(out_data)
);
